FILE: rtl/core/pspm_pkg.sv
// Package: shared types and constants for the pedal sensor monitor.
package pspm_pkg;

   localparam int unsigned RAW_W      = 12;
   localparam int unsigned PCT_W      = 13;
   localparam int unsigned ALPHA_W    = 9;
   localparam int unsigned NUM_LANES  = 3;
   localparam int unsigned FAULT_DELAY_DEF = 50;
   localparam int unsigned CNT_W      = 7;
   localparam int unsigned CSR_IDX_W  = 3;

   localparam logic [PCT_W-1:0] Q_ONE         = 13'd4096;
   localparam logic [PCT_W-1:0] DIFF_LIMIT    = 13'd409;
   localparam logic [PCT_W-1:0] PRESS_LEVEL   = 13'd1024;
   localparam logic [PCT_W-1:0] RELEASE_LEVEL = 13'd205;

   localparam logic [CSR_IDX_W-1:0] REG_APPS1_MIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_APPS1_MAX = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_APPS2_MIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_APPS2_MAX = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BRAKE_MIN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BRAKE_MAX = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_BRAKE_THR = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA     = 3'd7;

   typedef struct packed {
      logic [PCT_W-1:0] pct;
      logic             outside;
      logic             fault;
      logic [RAW_W-1:0] filt;
   } lane_res_type;

endpackage

FILE: rtl/core/pspm_lane.sv
// One sensor lane: low-pass filter, window check, serial divide scaling, range persistence.
module pspm_lane #(
   parameter int unsigned FAULT_DELAY = pspm_pkg::FAULT_DELAY_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [pspm_pkg::RAW_W-1:0]     raw,
   input  logic [pspm_pkg::RAW_W-1:0]     win_min,
   input  logic [pspm_pkg::RAW_W-1:0]     win_max,
   input  logic [pspm_pkg::ALPHA_W-1:0]   alpha,
   output logic                           done,
   output pspm_pkg::lane_res_type         res
);
   import pspm_pkg::*;

   localparam int unsigned NUM_W = RAW_W + 12;  // (f-min)*4096
   localparam int unsigned DEN_W = RAW_W;
   localparam int unsigned STEP_W = $clog2(NUM_W + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_FILT, ST_DIV} state_type;

   state_type          state_ff;
   logic [RAW_W-1:0]   prev_ff, prev_in;
   logic [RAW_W-1:0]   x_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [NUM_W-1:0]   quo_ff;
   logic [DEN_W:0]     rem_ff;
   logic [DEN_W-1:0]   den_ff;
   logic [STEP_W-1:0]  step_ff;
   logic               done_ff;
   lane_res_type       res_ff;

   logic [8:0]         a_sat;
   logic [21:0]        mix;
   logic               below, above;
   logic [DEN_W:0]     rem_sh;

   always_comb begin
      a_sat = (alpha > 9'd256) ? 9'd256 : alpha;
      mix = 22'(prev_ff) * 22'(9'd256 - a_sat) + 22'(a_sat) * 22'(x_ff);
      prev_in = mix[19:8];
      below = prev_in < win_min;
      above = prev_in > win_max;
      rem_sh = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         prev_ff  <= '0;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  x_ff     <= raw;
                  state_ff <= ST_FILT;
               end
            end
            ST_FILT: begin
               prev_ff     <= prev_in;
               res_ff.filt <= prev_in;
               res_ff.outside <= below | above;
               if (!(below | above)) begin
                  cnt_ff       <= '0;
                  res_ff.fault <= 1'b0;
               end else if (cnt_ff >= CNT_W'(FAULT_DELAY)) begin
                  cnt_ff       <= CNT_W'(FAULT_DELAY);
                  res_ff.fault <= 1'b1;
               end else begin
                  cnt_ff       <= cnt_ff + 1'b1;
                  res_ff.fault <= 1'b0;
               end
               if (below || (!above && win_max == win_min)) begin
                  res_ff.pct <= '0;
                  done_ff    <= 1'b1;
                  state_ff   <= ST_IDLE;
               end else if (above) begin
                  res_ff.pct <= Q_ONE;
                  done_ff    <= 1'b1;
                  state_ff   <= ST_IDLE;
               end else begin
                  quo_ff   <= {prev_in - win_min, 12'd0};
                  rem_ff   <= '0;
                  den_ff   <= win_max - win_min;
                  step_ff  <= '0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (rem_sh >= {1'b0, den_ff}) begin
                  rem_ff <= rem_sh - {1'b0, den_ff};
                  quo_ff <= {quo_ff[NUM_W-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  quo_ff <= {quo_ff[NUM_W-2:0], 1'b0};
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(NUM_W - 1)) begin
                  res_ff.pct <= (rem_sh >= {1'b0, den_ff}) ?
                                {quo_ff[PCT_W-2:0], 1'b1} : {quo_ff[PCT_W-2:0], 1'b0};
                  done_ff  <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign res  = res_ff;
endmodule

FILE: rtl/core/pspm_merge.sv
// Merge stage: disagreement persistence and latched brake plausibility fault.
module pspm_merge #(
   parameter int unsigned FAULT_DELAY = pspm_pkg::FAULT_DELAY_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         update,
   input  logic [pspm_pkg::PCT_W-1:0]   pct1,
   input  logic [pspm_pkg::PCT_W-1:0]   pct2,
   input  logic [pspm_pkg::RAW_W-1:0]   brake_filt,
   input  logic [pspm_pkg::RAW_W-1:0]   brake_thr,
   output logic                         disagree,
   output logic                         plaus
);
   import pspm_pkg::*;

   logic [CNT_W-1:0] cnt_ff;
   logic             dis_ff, pl_ff;
   logic [PCT_W-1:0] diff;

   assign diff = (pct1 > pct2) ? pct1 - pct2 : pct2 - pct1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         dis_ff <= 1'b0;
         pl_ff  <= 1'b0;
      end else if (update) begin
         if (diff > DIFF_LIMIT) begin
            if (cnt_ff >= CNT_W'(FAULT_DELAY)) begin
               cnt_ff <= CNT_W'(FAULT_DELAY);
               dis_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end else begin
            cnt_ff <= '0;
            dis_ff <= 1'b0;
         end
         if (brake_filt >= brake_thr && pct1 >= PRESS_LEVEL && pct2 >= PRESS_LEVEL)
            pl_ff <= 1'b1;
         else if (pct1 < RELEASE_LEVEL && pct2 < RELEASE_LEVEL)
            pl_ff <= 1'b0;
      end
   end

   assign disagree = dis_ff;
   assign plaus    = pl_ff;
endmodule

FILE: rtl/core/pedal_sensor_plausibility_monitor.sv
// Top level of the pedal sensor plausibility monitor.
// When no lane divides (out-of-window or empty-window samples), an accepted item passes
// the lane capture and filter states, the merge state and the output state; else each
// in-window lane runs a 24-step restoring divide after its filter. One item at a time:
// the next item is accepted the cycle after the result is taken.
// Reset clears filter history, counters, the merge fault flags and loads register defaults.
module pedal_sensor_plausibility_monitor #(
   parameter int unsigned FAULT_DELAY = pspm_pkg::FAULT_DELAY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // apps1_raw, apps2_raw, brake_raw, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // apps1_pct, apps2_pct, brake_pct, zero pad
   output logic [4:0]  rsp_tuser,  // apps1_rf, apps2_rf, brake_rf, disagree, plausibility
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_wdata
);
   import pspm_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_MERGE, ST_OUT} state_type;

   state_type                    state_ff;
   logic [RAW_W-1:0]             min_ff [NUM_LANES];
   logic [RAW_W-1:0]             max_ff [NUM_LANES];
   logic [RAW_W-1:0]             thr_ff;
   logic [ALPHA_W-1:0]           alpha_ff;
   logic [NUM_LANES-1:0]         got_ff;
   logic [NUM_LANES-1:0]         done;
   lane_res_type                 res [NUM_LANES];
   logic                         start;
   logic                         dis, pl;

   assign req_tready = (state_ff == ST_IDLE);
   assign start      = req_tvalid & req_tready;

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      pspm_lane #(.FAULT_DELAY(FAULT_DELAY)) u_lane (
         .clock   (clock),
         .reset   (reset),
         .start   (start),
         .raw     (req_tdata[g*RAW_W +: RAW_W]),
         .win_min (min_ff[g]),
         .win_max (max_ff[g]),
         .alpha   (alpha_ff),
         .done    (done[g]),
         .res     (res[g])
      );
   end

   pspm_merge #(.FAULT_DELAY(FAULT_DELAY)) u_merge (
      .clock      (clock),
      .reset      (reset),
      .update     (state_ff == ST_MERGE),
      .pct1       (res[0].pct),
      .pct2       (res[1].pct),
      .brake_filt (res[2].filt),
      .brake_thr  (thr_ff),
      .disagree   (dis),
      .plaus      (pl)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         got_ff   <= '0;
         for (int i = 0; i < NUM_LANES; i++) begin
            min_ff[i] <= '0;
            max_ff[i] <= 12'd4095;
         end
         thr_ff   <= 12'd2048;
         alpha_ff <= 9'd128;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_APPS1_MIN: min_ff[0] <= csr_wdata;
               REG_APPS1_MAX: max_ff[0] <= csr_wdata;
               REG_APPS2_MIN: min_ff[1] <= csr_wdata;
               REG_APPS2_MAX: max_ff[1] <= csr_wdata;
               REG_BRAKE_MIN: min_ff[2] <= csr_wdata;
               REG_BRAKE_MAX: max_ff[2] <= csr_wdata;
               REG_BRAKE_THR: thr_ff    <= csr_wdata;
               REG_ALPHA:     alpha_ff  <= csr_wdata[ALPHA_W-1:0];
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: if (start) begin
               got_ff   <= '0;
               state_ff <= ST_RUN;
            end
            ST_RUN: begin
               got_ff <= got_ff | done;
               if ((got_ff | done) == '1) state_ff <= ST_MERGE;
            end
            ST_MERGE: state_ff <= ST_OUT;
            ST_OUT: begin
               if (rsp_tvalid && rsp_tready) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {1'b0, res[2].pct, res[1].pct, res[0].pct};
   assign rsp_tuser  = {pl, dis, res[2].fault, res[1].fault, res[0].fault};
endmodule
